[rtl/core/sharpen_stencil_3x3_macros.svh]
`ifndef SHARPEN_STENCIL_3X3_MACROS_SVH
`define SHARPEN_STENCIL_3X3_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SHARP3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sharpen stencil check failed");

// Next-cycle implication, checked outside reset.
`define SHARP3_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sharpen stencil check failed");

// Condition that must hold in the cycle after a reset cycle.
`define SHARP3_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("sharpen stencil reset check failed");

`endif

[rtl/core/sharp3_pkg.sv]
package sharp3_pkg;

  // Sizes fixed by the beat formats
  localparam int PIX_W         = 8;
  localparam int NUM_CH        = 3;
  localparam int PIX_BITS      = PIX_W * NUM_CH;
  localparam int COLS_W        = 12;
  localparam int ROWS_W        = 16;
  localparam int CFG_W         = 16;

  // Defaults and filter constants
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int MAX_CHANNELS  = 3;
  localparam int CENTER_WEIGHT = 5;
  localparam int BORDER_VALUE  = 0;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;
  localparam int RESET_CHANS   = 3;
  localparam int MIN_DIM       = 3;

  // Queue depths
  localparam int CMD_DEPTH     = 4;
  localparam int OUT_DEPTH     = 2;

  // Operation codes
  localparam logic OP_PIXEL    = 1'b0;
  localparam logic OP_FLUSH    = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel_ch0;
    logic [PIX_W-1:0] pixel_ch1;
    logic [PIX_W-1:0] pixel_ch2;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_ch0;
    logic [PIX_W-1:0] out_ch1;
    logic [PIX_W-1:0] out_ch2;
    logic             frame_last;
  } out_beat_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [PIX_BITS-1:0] pix;
    logic                emit;
    logic                border;
    logic                last;
    logic [NUM_CH-1:0]   ch_en;
  } sharp3_cmd_t;

  // 5*c - l - r - u - d, clamped to 0..255
  function automatic logic [PIX_W-1:0] sharpen_px(
    input logic [PIX_W-1:0] c,
    input logic [PIX_W-1:0] l,
    input logic [PIX_W-1:0] r,
    input logic [PIX_W-1:0] u,
    input logic [PIX_W-1:0] d
  );
    logic        [10:0] c5;
    logic        [9:0]  s;
    logic signed [11:0] v;
    logic        [PIX_W-1:0] res;
    c5 = 11'(c) * 11'(CENTER_WEIGHT);
    s  = 10'(l) + 10'(r) + 10'(u) + 10'(d);
    v  = $signed({1'b0, c5}) - $signed({2'b00, s});
    if (v < 12'sd0) begin
      res = '0;
    end else if (v > 12'sd255) begin
      res = '1;
    end else begin
      res = v[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/sharpen_stencil_3x3.sv]
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  in_data   (in_beat_t)
// out      output     out_valid/out_stall out_data (out_beat_t)
// cfg      input      cfg_we             cfg_index, cfg_wdata
//
// One item per clock sustained while out_stall stays low; a result passes
// through the command queue, the line-buffer read and the output queue.
// The single line-buffer RAM (one read, one write port) sets that rate.
// Reset is synchronous: queues empty, window zero, registers 640/480/3.
// out_stall backs up the output queue, then the command queue, then in_stall.
module sharpen_stencil_3x3 import sharp3_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int QW = AW + $bits(sharp3_cmd_t);

  logic                           q_push, q_pop, q_full, q_empty;
  logic [AW-1:0]                  f_ic, b_ic;
  sharp3_cmd_t                    f_cmd, b_cmd;
  logic [$clog2(CMD_DEPTH+1)-1:0] q_count;

  // front: counters and classification
  sharp3_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ic     (f_ic),
    .q_cmd    (f_cmd)
  );

  // command queue between front and back
  sharp3_fifo #(
    .WIDTH(QW),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata({f_ic, f_cmd}),
    .pop  (q_pop),
    .rdata({b_ic, b_cmd}),
    .full (q_full),
    .empty(q_empty),
    .count(q_count)
  );

  // back: line buffers, window and stencil
  sharp3_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty || (q_count == '0)),
    .q_ic     (b_ic),
    .q_cmd    (b_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

[rtl/core/sharp3_ram.sv]
module sharp3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/sharp3_fifo.sv]
module sharp3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign full  = (count_r == NW'(DEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

[rtl/core/sharp3_front.sv]
module sharp3_front import sharp3_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  in_beat_t                     in_data,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [$clog2(MAX_WIDTH)-1:0] q_ic,
  output sharp3_cmd_t                  q_cmd
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > COLS_W) ? AW + 1 : COLS_W;

  logic [COLS_W-1:0] width_r;
  logic [ROWS_W-1:0] height_r;
  logic [1:0]        chcnt_r;

  logic [AW-1:0]     icol_r, ocol_r;
  logic [ROWS_W:0]   irow_r;
  logic [ROWS_W-1:0] orow_r;

  logic [CW-1:0]     cols, cols_m1, icol_inc, ocol_inc, ocol_ext;
  logic [ROWS_W-1:0] rows, rows_m1;
  logic [ROWS_W:0]   rows_p1;
  logic [1:0]        nch;
  logic              accept, emit, border, last;
  logic [NUM_CH-1:0] ch_en;

  // effective frame geometry and channel count
  always_comb begin
    if (width_r < COLS_W'(MIN_DIM)) begin
      cols = CW'(MIN_DIM);
    end else if (32'(width_r) > MAX_WIDTH) begin
      cols = CW'(MAX_WIDTH);
    end else begin
      cols = CW'(width_r);
    end
    rows = (height_r < ROWS_W'(MIN_DIM)) ? ROWS_W'(MIN_DIM) : height_r;
    if (chcnt_r == 2'd0) begin
      nch = 2'd1;
    end else if (32'(chcnt_r) > MAX_CHANNELS) begin
      nch = 2'(MAX_CHANNELS);
    end else begin
      nch = chcnt_r;
    end
    for (int i = 0; i < NUM_CH; i++) begin
      ch_en[i] = (2'(i) < nch);
    end
  end

  assign cols_m1  = cols - 1'b1;
  assign rows_m1  = rows - 1'b1;
  assign rows_p1  = {1'b0, rows} + 1'b1;
  assign icol_inc = CW'(icol_r) + 1'b1;
  assign ocol_ext = CW'(ocol_r);
  assign ocol_inc = ocol_ext + 1'b1;

  // classify the incoming item
  assign emit   = (irow_r >= (ROWS_W+1)'(2)) || (irow_r == (ROWS_W+1)'(1) && icol_r != '0);
  assign border = (orow_r == '0) || (orow_r == rows_m1) || (ocol_r == '0)
                  || (ocol_ext == cols_m1);
  assign last   = (orow_r == rows_m1) && (ocol_ext == cols_m1);

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;
  assign q_ic     = icol_r;

  always_comb begin
    q_cmd.pix    = (in_data.operation == OP_FLUSH) ? '0
                 : {in_data.pixel_ch2, in_data.pixel_ch1, in_data.pixel_ch0};
    q_cmd.emit   = emit;
    q_cmd.border = border;
    q_cmd.last   = last;
    q_cmd.ch_en  = ch_en;
  end

  // config registers and frame position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= COLS_W'(RESET_WIDTH);
      height_r <= ROWS_W'(RESET_HEIGHT);
      chcnt_r  <= 2'(RESET_CHANS);
      icol_r   <= '0;
      irow_r   <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          width_r <= cfg_wdata[COLS_W-1:0];
          icol_r <= '0; irow_r <= '0; ocol_r <= '0; orow_r <= '0;
        end
        CFG_IMAGE_HEIGHT: begin
          height_r <= cfg_wdata[ROWS_W-1:0];
          icol_r <= '0; irow_r <= '0; ocol_r <= '0; orow_r <= '0;
        end
        CFG_CHANNEL_COUNT: begin
          chcnt_r <= cfg_wdata[1:0];
          icol_r <= '0; irow_r <= '0; ocol_r <= '0; orow_r <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      // output position advances only on items that produce a beat
      if (emit) begin
        if (last) begin
          ocol_r <= '0;
          orow_r <= '0;
        end else if (ocol_inc >= cols) begin
          ocol_r <= '0;
          orow_r <= orow_r + 1'b1;
        end else begin
          ocol_r <= ocol_inc[AW-1:0];
        end
      end
      // input position; the flush tail's last item, in row rows+1, restarts the frame
      if (irow_r >= rows_p1) begin
        icol_r <= '0;
        irow_r <= '0;
      end else if (icol_inc >= cols) begin
        icol_r <= '0;
        irow_r <= irow_r + 1'b1;
      end else begin
        icol_r <= icol_inc[AW-1:0];
      end
    end
  end

endmodule

[rtl/core/sharp3_back.sv]
module sharp3_back import sharp3_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_ic,
  input  sharp3_cmd_t                  q_cmd,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output out_beat_t                    out_data
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int LW  = 2 * PIX_BITS;
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  // stage A: item whose line-buffer read is in flight
  logic                a_valid_r;
  logic [AW-1:0]       a_ic_r;
  sharp3_cmd_t         a_cmd_r;

  // collision bypass for a read of the address written in the same cycle
  logic                fwd_r;
  logic [LW-1:0]       fwd_data_r;

  // window columns: left-center, upper, center, lower
  logic [PIX_BITS-1:0] w1_r, w3_r, w4_r, w5_r;

  logic [LW-1:0]       ram_rdata, line;
  logic [PIX_BITS-1:0] up, mid;
  logic [PIX_W-1:0]    res [NUM_CH];
  out_beat_t           beat;
  logic                of_push, of_pop, of_full, of_empty;
  logic [OCW-1:0]      of_count;
  logic                credit;
  logic                fwd_nxt;

  // issue a pop only when the output queue is sure to have room
  assign of_pop  = !of_empty && !out_stall;
  assign of_push = a_valid_r && a_cmd_r.emit;
  assign credit  = ((OCW+1)'(of_count) + (OCW+1)'(of_push) + 1'b1)
                   <= ((OCW+1)'(OUT_DEPTH) + (OCW+1)'(of_pop));
  assign q_pop   = !q_empty && credit;
  assign fwd_nxt = q_pop && a_valid_r && (a_ic_r == q_ic);

  sharp3_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (a_valid_r),
    .waddr(a_ic_r),
    .wdata({mid, a_cmd_r.pix}),
    .re   (q_pop),
    .raddr(q_ic),
    .rdata(ram_rdata)
  );

  assign line = fwd_r ? fwd_data_r : ram_rdata;
  assign up   = line[LW-1:PIX_BITS];
  assign mid  = line[PIX_BITS-1:0];

  // per-channel stencil
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (a_cmd_r.border || !a_cmd_r.ch_en[ch]) begin
        res[ch] = PIX_W'(BORDER_VALUE);
      end else begin
        res[ch] = sharpen_px(w4_r[ch*PIX_W +: PIX_W], w1_r[ch*PIX_W +: PIX_W],
                             mid[ch*PIX_W +: PIX_W], w3_r[ch*PIX_W +: PIX_W],
                             w5_r[ch*PIX_W +: PIX_W]);
      end
    end
    beat.out_ch0    = res[0];
    beat.out_ch1    = res[1];
    beat.out_ch2    = res[2];
    beat.frame_last = a_cmd_r.last;
  end

  // stage A control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      a_valid_r <= q_pop;
      fwd_r     <= fwd_nxt;
    end
  end

  // stage A payload and bypass data
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_ic_r  <= q_ic;
      a_cmd_r <= q_cmd;
    end
    fwd_data_r <= {mid, a_cmd_r.pix};
  end

  // window shift, once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_r <= '0;
      w3_r <= '0;
      w4_r <= '0;
      w5_r <= '0;
    end else if (a_valid_r) begin
      w1_r <= w4_r;
      w3_r <= up;
      w4_r <= mid;
      w5_r <= a_cmd_r.pix;
    end
  end

  sharp3_fifo #(
    .WIDTH($bits(out_beat_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (of_push),
    .wdata(beat),
    .pop  (of_pop),
    .rdata(out_data),
    .full (of_full),
    .empty(of_empty),
    .count(of_count)
  );

  assign out_valid = !of_empty && !(of_full && of_empty);

endmodule

[rtl/core/sharp3_checker.sv]
module sharp3_checker import sharp3_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

`include "sharpen_stencil_3x3_macros.svh"

  // a held beat keeps its payload
  `SHARP3_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // the last pixel of a frame is a corner, so it is always blank
  `SHARP3_ASSERT_IMP(a_last_blank, out_valid && out_data.frame_last, out_data.out_ch0 == '0 && out_data.out_ch1 == '0 && out_data.out_ch2 == '0)

  // queues come out of reset empty
  `SHARP3_ASSERT_RST(a_rst_out_idle, !out_valid)
  `SHARP3_ASSERT_RST(a_rst_in_open, !in_stall)

endmodule

bind sharpen_stencil_3x3 sharp3_checker u_sharp3_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

[test/sharpen_stencil_3x3_checker.sv]
`timescale 1ns / 100ps

// Watches the config port and both beat channels, keeps its own copy of the
// stencil state and compares every output beat with the oldest prediction.
module sharpen_stencil_3x3_checker import sharp3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_beat_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_beat_t        out_data,
  output int               mismatches,
  output int               results_due
);

  localparam int LINE_DEPTH = DEF_MAX_WIDTH;
  localparam int MAX_PRINTS = 40;

  // Shadow of the filter state
  logic [PIX_BITS-1:0] upper_row_buf [LINE_DEPTH];
  logic [PIX_BITS-1:0] middle_row_buf [LINE_DEPTH];
  logic [PIX_BITS-1:0] win [6];
  int unsigned         in_col, in_row, out_col, out_row;
  logic [COLS_W-1:0]   width_q;
  logic [ROWS_W-1:0]   height_q;
  logic [1:0]          chans_q;
  out_beat_t           sharpened_q [$];

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  function automatic logic [PIX_W-1:0] lane(logic [PIX_BITS-1:0] w, int ch);
    return w[PIX_W*ch +: PIX_W];
  endfunction

  // 5*center minus the left, right, upper and lower neighbors, saturated to a byte
  function automatic logic [PIX_W-1:0] sharpen_pixel(
    logic [PIX_W-1:0] c, logic [PIX_W-1:0] l, logic [PIX_W-1:0] r,
    logic [PIX_W-1:0] u, logic [PIX_W-1:0] d
  );
    int v;
    v = CENTER_WEIGHT * int'(c) - int'(l) - int'(r) - int'(u) - int'(d);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  task automatic restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic apply_config(logic [1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_IMAGE_WIDTH: begin
        width_q = data[COLS_W-1:0];
        restart_frame();
      end
      CFG_IMAGE_HEIGHT: begin
        height_q = data[ROWS_W-1:0];
        restart_frame();
      end
      CFG_CHANNEL_COUNT: begin
        chans_q = data[1:0];
        restart_frame();
      end
      default: ;
    endcase
  endtask

  // One input beat: shift the window, update the line buffers and, from the second
  // pixel of the second row on, queue the sharpened pixel it completes.
  task automatic advance_stencil(in_beat_t b);
    int unsigned         cols, rows, nch, ic, ir;
    logic [PIX_BITS-1:0] pix, up, mid;
    logic [PIX_W-1:0]    lanes [NUM_CH];
    bit                  border, last;
    out_beat_t           res;
    cols = 32'(width_q);
    if (cols < MIN_DIM) cols = MIN_DIM;
    if (cols > LINE_DEPTH) cols = LINE_DEPTH;
    rows = 32'(height_q);
    if (rows < MIN_DIM) rows = MIN_DIM;
    nch = 32'(chans_q);
    if (nch == 0) nch = 1;
    if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
    ic = in_col % LINE_DEPTH;
    ir = in_row;
    pix = (b.operation == OP_PIXEL) ? {b.pixel_ch2, b.pixel_ch1, b.pixel_ch0} : '0;
    up = upper_row_buf[ic];
    mid = middle_row_buf[ic];

    if (ir >= 2 || (ir == 1 && ic >= 1)) begin
      border = out_row == 0 || out_row == rows - 1 || out_col == 0 || out_col == cols - 1;
      last = out_row == rows - 1 && out_col == cols - 1;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (!border && ch < nch) begin
          lanes[ch] = sharpen_pixel(lane(win[4], ch), lane(win[1], ch), lane(mid, ch),
                                    lane(win[3], ch), lane(win[5], ch));
        end else begin
          lanes[ch] = PIX_W'(BORDER_VALUE);
        end
      end
      res.out_ch0 = lanes[0];
      res.out_ch1 = lanes[1];
      res.out_ch2 = lanes[2];
      res.frame_last = last;
      sharpened_q.push_back(res);
      if (last) begin
        out_row = 0;
        out_col = 0;
      end else begin
        out_col++;
        if (out_col >= cols) begin
          out_col = 0;
          out_row++;
        end
      end
    end

    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = up;
    win[4] = mid;
    win[5] = pix;
    upper_row_buf[ic] = mid;
    middle_row_buf[ic] = pix;

    if (ir >= rows + 1) begin
      in_row = 0;
      in_col = 0;
    end else begin
      in_col++;
      if (in_col >= cols) begin
        in_col = 0;
        in_row++;
      end
    end
  endtask

  // Outputs are checked before the same-edge input is predicted: no beat leaves in
  // the cycle its input is taken, so a beat leaving now belongs to an earlier input.
  always @(posedge clk) begin : monitor
    out_beat_t want;
    if (!rst_n) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        upper_row_buf[i] = '0;
        middle_row_buf[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      restart_frame();
      width_q = COLS_W'(RESET_WIDTH);
      height_q = ROWS_W'(RESET_HEIGHT);
      chans_q = 2'(RESET_CHANS);
      sharpened_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sharpened_q.size() == 0) begin
          report_mismatch($sformatf("output beat %h with nothing pending", out_data));
        end else begin
          want = sharpened_q.pop_front();
          check_field("out_ch0", out_data.out_ch0, want.out_ch0);
          check_field("out_ch1", out_data.out_ch1, want.out_ch1);
          check_field("out_ch2", out_data.out_ch2, want.out_ch2);
          check_field("frame_last", PIX_W'(out_data.frame_last), PIX_W'(want.frame_last));
        end
      end
      if (cfg_we) apply_config(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) advance_stencil(in_data);
    end
    results_due = sharpened_q.size();
  end

endmodule

[test/sharpen_stencil_3x3_tb.sv]
`timescale 1ns / 100ps

module sharpen_stencil_3x3_tb;
  import sharp3_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_LIMIT   = 2000;
  localparam int WIDE_BURST   = 40;
  // Index past the last register; writes to it must change nothing
  localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_beat_t        out_data;

  int mismatches;
  int results_due;
  int items_sent = 0;
  int idle_cycles = 0;
  int cur_cols;
  int cur_rows;
  bit sender_fast = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_on = 1'b0;

  sharpen_stencil_3x3 DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sharpen_stencil_3x3_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always #5 clk = ~clk;

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom);
  endfunction

  function automatic int frame_len();
    return cur_rows * cur_cols + cur_cols + 1;
  endfunction

  // 3x3 frames for the opening checks; k is the raster index incl. flush tail
  function automatic in_beat_t demo_beat(int pass, int k);
    in_beat_t b;
    b.operation = (k < 9) ? OP_PIXEL : OP_FLUSH;
    b.pixel_ch2 = PIX_W'($urandom);
    if (pass == 0) begin
      b.pixel_ch0 = (k == 4) ? 8'hFF : 8'h00;  // bright center saturates high
      b.pixel_ch1 = (k == 4) ? 8'h00 : 8'hFF;  // dark center saturates low
      if (k == 6) b.operation = OP_FLUSH;      // flush among pixels, corner only
      if (k == 10) b.operation = OP_PIXEL;     // data inside the flush tail
    end else begin
      b.pixel_ch0 = (k == 4) ? 8'd60 : PIX_W'(k * 4);
      b.pixel_ch1 = 8'hFF;                     // inactive lanes must read zero
    end
    return b;
  endfunction

  // Offer one beat and hold it until taken
  task automatic send_beat(in_beat_t b);
    int gap;
    gap = sender_fast ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Sender goes quiet until every predicted beat has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    @(posedge clk);
  endtask

  // Idle point: drained, plus time for beats that produce no output
  task automatic settle();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Back-to-back register writes; called only while the block is idle
  task automatic program_regs(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                              logic [CFG_W-1:0] c, bit spare);
    cfg_we <= 1'b1;
    if (spare) begin
      cfg_index <= CFG_SPARE_INDEX;
      cfg_wdata <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= CFG_CHANNEL_COUNT;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cols = int'(w[COLS_W-1:0]);
    if (cur_cols < MIN_DIM) cur_cols = MIN_DIM;
    if (cur_cols > DEF_MAX_WIDTH) cur_cols = DEF_MAX_WIDTH;
    cur_rows = int'(h[ROWS_W-1:0]);
    if (cur_rows < MIN_DIM) cur_rows = MIN_DIM;
  endtask

  // Raster beats with random content; a few operation flags are flipped
  task automatic send_frame(int count);
    int       pixels;
    in_beat_t b;
    pixels = cur_rows * cur_cols;
    for (int k = 0; k < count; k++) begin
      b.operation = (k < pixels) ? OP_PIXEL : OP_FLUSH;
      if ($urandom_range(0, 19) == 0) b.operation = ~b.operation;
      b.pixel_ch0 = rand_sample();
      b.pixel_ch1 = rand_sample();
      b.pixel_ch2 = rand_sample();
      send_beat(b);
      if ($urandom_range(0, 399) == 0) drain_results();
    end
  endtask

  // Result side: random stall pattern plus one long hold-off on request
  initial begin : receiver
    bit held;
    int run;
    int stall;
    held = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        hold_on = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 6);
        out_stall <= 1'b0;
        repeat (run) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          out_stall <= 1'b1;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: too long without any beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int frames;
    int w;
    int h;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening 3x3 frames: widths/heights below minimum, zero channel count
    program_regs(16'h0001, 16'h0002, 16'h0003, 1'b1);
    for (int k = 0; k < 13; k++) send_beat(demo_beat(0, k));
    settle();
    program_regs(16'hF003, 16'h0000, 16'h0000, 1'b0);
    for (int k = 0; k < 13; k++) send_beat(demo_beat(1, k));
    settle();

    // Long output hold-off while beats keep coming, so the block backs up;
    // the frame starts only once the receiver is holding
    program_regs(16'd12, 16'd8, 16'd3, 1'b0);
    sender_fast = 1'b1;
    hold_off_req <= 1'b1;
    wait (hold_on);
    send_frame(frame_len());
    sender_fast = 1'b0;
    settle();

    // Random phases: mostly small frames, now and then a wider one
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(20, 70);
        h = $urandom_range(3, 4);
      end else begin
        w = $urandom_range(0, 12);
        h = $urandom_range(0, 8);
      end
      program_regs({4'($urandom), 12'(w)}, 16'(h),
                   {14'($urandom), 2'($urandom_range(0, 3))},
                   $urandom_range(0, 9) == 0);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        sender_fast = $urandom_range(0, 3) == 0;
        if (f == frames - 1 && $urandom_range(0, 5) == 0) begin
          send_frame($urandom_range(1, frame_len() - 1));
        end else begin
          send_frame(frame_len());
        end
      end
      sender_fast = 1'b0;
      settle();
    end

    // Largest width and height: a short burst into a frame left open
    program_regs(16'hFFFF, 16'hFFFF, 16'h0002, 1'b0);
    send_frame(WIDE_BURST);
    settle();

    if (mismatches == 0 && results_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
